/* src/pbnc_pkg.sv */
// ----------------------------------------------------------------------------
// pbnc_pkg - shared definitions for the palette builder
// Hint colors, outcome codes, sequencer states and sizing defaults.
// ----------------------------------------------------------------------------
package pbnc_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int HINT_COUNT   = 3;
	localparam int DIST_W       = 18;  // 3 * 255^2 fits in 18 bits

	localparam logic [23:0] HINT_COLOR [HINT_COUNT] = '{
		24'hD02020, 24'h20D020, 24'h2020D0
	};

	typedef enum logic [1:0] {
		OUT_MATCH   = 2'd0,
		OUT_ADDED   = 2'd1,
		OUT_NEAREST = 2'd2
	} outcome_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

/* src/pbnc_ram.sv */
// ----------------------------------------------------------------------------
// pbnc_ram - simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbnc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/palette_builder_nearest_color.sv */
// ----------------------------------------------------------------------------
// palette_builder_nearest_color - pixel to palette index mapper
// Builds the palette on the fly: exact match, append, or nearest entry.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------
//  pixel in | red, green, blue, new_image      | start while busy low
//  result   | color_index, outcome             | done, one cycle, no back-pressure
//
//  With no exact match the done strobe is registered from the compare of the
//  last entry in use; a match at index k ends the scan early, with done
//  registered from the compare of entry k. Busy drops with done, so the next
//  pixel can be accepted while done is high.
//  The scan length is set by the single read port of the palette RAM: one entry
//  is fetched per cycle and fed to the shared distance/compare unit.
//  Reset leaves the three hint colors in place and entry_count at 3; the
//  RAM needs no clearing since entries at or above entry_count are never read.
//  The receiver cannot stall: each result is shown for one cycle only.
//
module palette_builder_nearest_color #(
	parameter int PALETTE_SIZE = pbnc_pkg::PALETTE_SIZE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       new_image,
	output logic       done,
	output logic [7:0] color_index,
	output logic [1:0] outcome
);

	localparam int IW = $clog2(PALETTE_SIZE);       // entry index
	localparam int CW = $clog2(PALETTE_SIZE + 1);   // entry count
	localparam int DW = pbnc_pkg::DIST_W;

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	pbnc_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;     // entries in use, 3 .. PALETTE_SIZE
	logic [CW-1:0] rd_idx_q;    // next entry to fetch
	logic          valid_s1, valid_s2;
	logic          last_s1, last_s2;
	logic [IW-1:0] idx_s1, idx_s2;

	// Pixel under work
	logic [7:0] red_q, green_q, blue_q;

	// Best nearest candidate so far
	logic [DW-1:0] best_dist_q;
	logic [IW-1:0] best_idx_q;

	// Result registers
	logic       done_q;
	logic [7:0] color_index_q;
	pbnc_pkg::outcome_t outcome_q;

	logic accept;
	logic issue;
	logic fin_match, fin_end, finish;
	logic full;

	assign accept = start && (state_q == pbnc_pkg::ST_IDLE);
	assign full   = (count_q == CW'(PALETTE_SIZE));

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbnc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = pbnc_pkg::ST_SCAN;
				end
			end
			pbnc_pkg::ST_SCAN: begin
				if (finish) begin
					state_d = pbnc_pkg::ST_IDLE;
				end
			end
			default: state_d = pbnc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		busy  = 1'b0;
		issue = 1'b0;
		case (state_q)
			pbnc_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			pbnc_pkg::ST_SCAN: begin
				busy  = 1'b1;
				issue = (rd_idx_q < count_q) && !finish;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Palette RAM. Entries below the hint count live in constants; the
	// RAM slots for them are simply never used.
	// ------------------------------------------------------------------
	logic [23:0] ram_rdata;
	logic        ram_we;

	assign ram_we = fin_end && !full;

	pbnc_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_SIZE)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata ({red_q, green_q, blue_q}),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: entry available; match test and per-channel squares
	// ------------------------------------------------------------------
	logic [23:0] entry_s1;
	logic [7:0]  dr, dg, db;
	logic        match_s2;
	logic [15:0] sq_r_s2, sq_g_s2, sq_b_s2;

	always_comb begin
		entry_s1 = ram_rdata;
		if (idx_s1 < IW'(pbnc_pkg::HINT_COUNT)) begin
			entry_s1 = pbnc_pkg::HINT_COLOR[idx_s1[1:0]];
		end
		dr = (red_q   > entry_s1[23:16]) ? red_q   - entry_s1[23:16]
		                                 : entry_s1[23:16] - red_q;
		dg = (green_q > entry_s1[15:8])  ? green_q - entry_s1[15:8]
		                                 : entry_s1[15:8] - green_q;
		db = (blue_q  > entry_s1[7:0])   ? blue_q  - entry_s1[7:0]
		                                 : entry_s1[7:0] - blue_q;
	end

	always_ff @(posedge clk) begin
		match_s2 <= (entry_s1 == {red_q, green_q, blue_q});
		sq_r_s2  <= 16'(dr) * 16'(dr);
		sq_g_s2  <= 16'(dg) * 16'(dg);
		sq_b_s2  <= 16'(db) * 16'(db);
		idx_s2   <= idx_s1;
		last_s2  <= last_s1;
		idx_s1   <= rd_idx_q[IW-1:0];
		last_s1  <= (rd_idx_q == count_q - CW'(1));
	end

	// ------------------------------------------------------------------
	// Stage 2: distance sum, compare against best, end of scan
	// ------------------------------------------------------------------
	logic [DW-1:0] dist_s2;
	logic          better;
	logic [IW-1:0] best_idx_nx;

	assign dist_s2     = DW'(sq_r_s2) + DW'(sq_g_s2) + DW'(sq_b_s2);
	assign better      = valid_s2 && (dist_s2 < best_dist_q);
	assign best_idx_nx = better ? idx_s2 : best_idx_q;

	assign fin_match = valid_s2 && match_s2;
	assign fin_end   = valid_s2 && !match_s2 && last_s2;
	assign finish    = fin_match || fin_end;

	always_ff @(posedge clk) begin
		if (accept) begin
			red_q       <= red;
			green_q     <= green;
			blue_q      <= blue;
			best_dist_q <= '1;
			best_idx_q  <= '0;
		end else if (better) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= idx_s2;
		end
		if (fin_match) begin
			color_index_q <= 8'(idx_s2);
			outcome_q     <= pbnc_pkg::OUT_MATCH;
		end else if (full) begin
			color_index_q <= 8'(best_idx_nx);
			outcome_q     <= pbnc_pkg::OUT_NEAREST;
		end else begin
			color_index_q <= 8'(count_q[IW-1:0]);
			outcome_q     <= pbnc_pkg::OUT_ADDED;
		end
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pbnc_pkg::ST_IDLE;
			count_q  <= CW'(pbnc_pkg::HINT_COUNT);
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (accept) begin
				rd_idx_q <= '0;
				if (new_image) begin
					count_q <= CW'(pbnc_pkg::HINT_COUNT);
				end
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			// flush in-flight fetches once the transaction ends
			valid_s1 <= issue;
			valid_s2 <= valid_s1 && !finish;
		end
	end

	assign done        = done_q;
	assign color_index = color_index_q;
	assign outcome     = outcome_q;

endmodule

/* tb/tb_palette_builder_nearest_color.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_builder_nearest_color - self-checking bench for the palette mapper
// Sends pixels with random pauses and keeps its own copy of the palette. Every
// done strobe is checked, index and outcome, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_palette_builder_nearest_color;

	localparam int CLK_HALF     = 5;
	localparam int CYCLE_LIMIT  = 1_000_000;  // watchdog bound on total clock cycles
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 500;        // images stop here, then the burst
	localparam int BURST_ITEMS  = 50;
	localparam int SETTLE       = pbnc_pkg::PALETTE_SIZE + 16;  // longest scan plus margin

	// one expected transaction on the result side
	typedef struct {
		logic [7:0]         idx;
		pbnc_pkg::outcome_t kind;
	} pixel_map_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       new_image;
	logic       done;
	logic [7:0] color_index;
	logic [1:0] outcome;

	// predictor state: the bench's own palette and fill level
	logic [23:0] palette_copy [pbnc_pkg::PALETTE_SIZE];
	int          n_entries;

	pixel_map_t  expected_maps [$];
	int          mism_count;
	int          items_sent;
	int          cycles;
	bit          quiet;  // no idling in the closing burst

	palette_builder_nearest_color u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.new_image  (new_image),
		.done       (done),
		.color_index(color_index),
		.outcome    (outcome)
	);

	always #CLK_HALF clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL palette_builder_nearest_color");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// back to the three hint colors; entries above are never compared
	function automatic void load_hint_palette();
		for (int k = 0; k < pbnc_pkg::PALETTE_SIZE; k++)
			palette_copy[k] = (k < pbnc_pkg::HINT_COUNT) ? pbnc_pkg::HINT_COLOR[k] : 24'h0;
		n_entries = pbnc_pkg::HINT_COUNT;
	endfunction

	// exact match first (lowest index), else append, else nearest with the
	// lowest index on a tie -- the strict less-than keeps the earlier entry
	function automatic pixel_map_t map_pixel(input logic [23:0] c, input logic fresh);
		pixel_map_t  res;
		int unsigned best_d;
		int unsigned d;
		int          best_k;
		int          dr;
		int          dg;
		int          db;
		if (fresh)
			load_hint_palette();
		best_d = 32'hFFFF_FFFF;
		best_k = 0;
		for (int k = 0; k < n_entries; k++) begin
			if (palette_copy[k] == c) begin
				res.idx  = k[7:0];
				res.kind = pbnc_pkg::OUT_MATCH;
				return res;
			end
			dr = int'(c[23:16]) - int'(palette_copy[k][23:16]);
			dg = int'(c[15:8])  - int'(palette_copy[k][15:8]);
			db = int'(c[7:0])   - int'(palette_copy[k][7:0]);
			d  = dr * dr + dg * dg + db * db;
			if (d < best_d) begin
				best_d = d;
				best_k = k;
			end
		end
		if (n_entries < pbnc_pkg::PALETTE_SIZE) begin
			palette_copy[n_entries] = c;
			res.idx  = n_entries[7:0];
			res.kind = pbnc_pkg::OUT_ADDED;
			n_entries++;
		end else begin
			res.idx  = best_k[7:0];
			res.kind = pbnc_pkg::OUT_NEAREST;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Result checker: the receiver cannot stall, so every strobe is taken
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		pixel_map_t want;
		if (arst_n && done) begin
			if (expected_maps.size() == 0) begin
				mism_count++;
				if (mism_count <= MAX_REPORTS)
					$display("%0t: unexpected result idx=%0d outcome=%0d",
						$realtime, color_index, outcome);
			end else begin
				want = expected_maps.pop_front();
				if (color_index !== want.idx || outcome !== want.kind) begin
					mism_count++;
					if (mism_count <= MAX_REPORTS)
						$display("%0t: mismatch idx exp=%0d got=%0d, outcome exp=%0d got=%0d",
							$realtime, want.idx, color_index, want.kind, outcome);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------------

	// one pixel transaction; start stays high into the next call unless we idle
	task automatic send_pixel(input logic [23:0] c, input logic fresh);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			// sometimes let the scan finish first so the gap lands after busy
			if ($urandom_range(0, 1) == 1)
				do @(posedge clk); while (busy);
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start     <= 1'b1;
		red       <= c[23:16];
		green     <= c[15:8];
		blue      <= c[7:0];
		new_image <= fresh;
		do @(posedge clk); while (busy);
		expected_maps.push_back(map_pixel(c, fresh));
		items_sent++;
	endtask

	// hold the sender off until every result is back
	task automatic wait_all_mapped();
		start <= 1'b0;
		do @(posedge clk); while (expected_maps.size() != 0);
	endtask

	// one image: mostly repeats and random colors, a few hints and near misses
	task automatic run_image(input int len, input bit fresh);
		logic [23:0] seen [$];
		logic [23:0] c;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: c = (seen.size() != 0) ?
					seen[$urandom_range(0, seen.size() - 1)] : 24'($urandom);
				4:          c = pbnc_pkg::HINT_COLOR[$urandom_range(0, pbnc_pkg::HINT_COUNT - 1)];
				5:          c = (seen.size() != 0) ?
					seen[seen.size() - 1] ^ (24'h1 << $urandom_range(0, 23)) : 24'($urandom);
				default:    c = 24'($urandom);
			endcase
			send_pixel(c, fresh && i == 0);
			seen.push_back(c);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// palette after reset already holds the hints, no new-image flag needed
	task automatic test_reset_hints();
		send_pixel(pbnc_pkg::HINT_COLOR[2], 1'b0);
		send_pixel(pbnc_pkg::HINT_COLOR[0], 1'b0);
		send_pixel(pbnc_pkg::HINT_COLOR[1], 1'b0);
	endtask

	// channel extremes and alternating bit patterns get appended, then matched
	task automatic test_append_extremes();
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hAAAAAA, 1'b0);
		send_pixel(24'h555555, 1'b0);
		send_pixel(24'hFF0000, 1'b0);
		send_pixel(24'h00FF00, 1'b0);
		send_pixel(24'h0000FF, 1'b0);
		send_pixel(24'hD02021, 1'b0);  // one LSB off a hint: no match
		send_pixel(24'h555555, 1'b0);
	endtask

	// new image drops the appended entries; stale RAM contents must not match
	task automatic test_new_image();
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hAAAAAA, 1'b0);
		send_pixel(24'h20D020, 1'b1);
		send_pixel(24'h000000, 1'b1);
		send_pixel(24'h2020D0, 1'b0);
	endtask

	// fill to the last slot on a coarse grid, then probe the nearest search;
	// midpoint probes sit between grid colors so ties are frequent
	task automatic test_full_palette();
		logic [23:0] c;
		send_pixel({4'($urandom), 4'h0, 4'($urandom), 4'h0, 4'($urandom), 4'h0}, 1'b1);
		while (n_entries < pbnc_pkg::PALETTE_SIZE)
			send_pixel({4'($urandom), 4'h0, 4'($urandom), 4'h0, 4'($urandom), 4'h0}, 1'b0);
		repeat (40) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: c = {4'($urandom), 4'h8, 4'($urandom), 4'h8, 4'($urandom), 4'h8};
				4, 5, 6:    c = palette_copy[$urandom_range(0, pbnc_pkg::PALETTE_SIZE - 1)];
				default:    c = 24'($urandom);
			endcase
			send_pixel(c, 1'b0);
		end
	endtask

	// random images of mixed length; a fifth continue the previous palette
	task automatic test_random_images();
		while (items_sent < RANDOM_ITEMS)
			run_image($urandom_range(1, 40), $urandom_range(0, 4) != 0);
	endtask

	// closing burst with start held high back to back
	task automatic test_back_to_back();
		quiet = 1'b1;
		run_image(BURST_ITEMS / 2, 1'b1);
		run_image(BURST_ITEMS / 2, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		red        = 8'h00;
		green      = 8'h00;
		blue       = 8'h00;
		new_image  = 1'b0;
		cycles     = 0;
		mism_count = 0;
		items_sent = 0;
		quiet      = 1'b0;
		load_hint_palette();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_hints();
		test_append_extremes();
		test_new_image();
		wait_all_mapped();
		test_full_palette();
		test_random_images();
		wait_all_mapped();
		test_back_to_back();

		wait_all_mapped();
		repeat (SETTLE) @(posedge clk);
		mism_count += expected_maps.size();

		if (mism_count == 0)
			$display("PASS palette_builder_nearest_color");
		else
			$display("FAIL palette_builder_nearest_color");
		$finish;
	end

endmodule
